FILE: rtl/core/ipf_pkg.sv
// Shared types and constants for the IPv4 header packet filter.
package ipf_pkg;

  localparam int unsigned MaxFrameBytesDefault = 2048;

  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIndexW = 3;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam int unsigned WordBytes     = 4;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  // Frame offsets of the captured fields.
  localparam int unsigned OffEtherHi  = 12;
  localparam int unsigned OffEtherLo  = 13;
  localparam int unsigned OffIhl      = 14;
  localparam int unsigned OffProtocol = 23;
  localparam int unsigned OffSrcFirst = 26;
  localparam int unsigned OffSrcLast  = 29;
  localparam int unsigned OffDstFirst = 30;
  localparam int unsigned OffDstLast  = 33;

  // Minimum frame lengths needed to reach each field.
  localparam int unsigned MinLenEther    = 14;
  localparam int unsigned MinLenProtocol = 24;
  localparam int unsigned MinLenAddress  = 34;

  // Port offsets fit in 7 bits: 14 + 4 * 15 + 4 = 78.
  localparam int unsigned PortOffW = 7;

  typedef enum logic [2:0] {
    VerdictAccept   = 3'd0,
    VerdictLimit    = 3'd1,
    VerdictShort    = 3'd2,
    VerdictNotIpv4  = 3'd3,
    VerdictProtocol = 3'd4,
    VerdictAddress  = 3'd5,
    VerdictPort     = 3'd6
  } verdict_e;

  typedef enum logic [1:0] {
    ClassAny  = 2'd0,
    ClassTcp  = 2'd1,
    ClassUdp  = 2'd2,
    ClassIcmp = 2'd3
  } proto_class_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgProtocolNumber = 3'd0,
    CfgProtocolClass  = 3'd1,
    CfgAddrEnable     = 3'd2,
    CfgSrcAddr        = 3'd3,
    CfgDstAddr        = 3'd4,
    CfgSrcPort        = 3'd5,
    CfgDstPort        = 3'd6,
    CfgAcceptLimit    = 3'd7
  } cfg_index_e;

endpackage

FILE: rtl/core/ipf_channels.sv
// Valid/ready channel interfaces for frame bytes in and verdicts out.
interface ipf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface ipf_verdict_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [7:0]  found_protocol;
  logic [15:0] found_source_port;
  logic [15:0] found_destination_port;
  logic [31:0] accepted_total;

  modport source (output valid, output verdict, output found_protocol,
                  output found_source_port, output found_destination_port,
                  output accepted_total, input ready);
  modport sink (input valid, input verdict, input found_protocol,
                input found_source_port, input found_destination_port,
                input accepted_total, output ready);
endinterface

FILE: rtl/core/ipv4_header_packet_filter_core.sv
// IPv4 five-tuple packet filter: byte-stream field capture and per-frame verdict.
//
//   Channel   Dir  Handshake     Payload
//   frame_i   in   valid/ready   frame_byte[7:0], last_byte
//   result_o  out  valid/ready   verdict[2:0], found_protocol[7:0], found ports[15:0] x2,
//                                accepted_total[31:0]
//   cfg_*_i   in   write enable  cfg_index_i[2:0], cfg_data_i[31:0]
//
// One byte is taken per cycle unless a last byte waits. A byte is held in the input register,
// then the capture and the verdict logic update the frame state and load the result register.
// Reset clears the configuration, the frame state, the accept counter and all valids.
// Only a last byte waits on a full result register; other bytes keep flowing.
module ipv4_header_packet_filter_core
  import ipf_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ipf_byte_if.sink             frame_i,
  ipf_verdict_if.source        result_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned OffW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [OffW-1:0] MaxOff = OffW'(MAX_FRAME_BYTES);

  // Configuration registers.
  logic [7:0]  proto_match_q;
  logic [1:0]  proto_class_q;
  logic [1:0]  addr_en_q;
  logic [31:0] src_addr_match_q;
  logic [31:0] dst_addr_match_q;
  logic [15:0] l4_src_match_q;
  logic [15:0] l4_dst_match_q;
  logic [31:0] accept_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_match_q    <= '0;
      proto_class_q    <= '0;
      addr_en_q        <= '0;
      src_addr_match_q <= '0;
      dst_addr_match_q <= '0;
      l4_src_match_q   <= '0;
      l4_dst_match_q   <= '0;
      accept_limit_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgProtocolNumber: proto_match_q    <= cfg_data_i[7:0];
        CfgProtocolClass:  proto_class_q    <= cfg_data_i[1:0];
        CfgAddrEnable:     addr_en_q        <= cfg_data_i[1:0];
        CfgSrcAddr:        src_addr_match_q <= cfg_data_i;
        CfgDstAddr:        dst_addr_match_q <= cfg_data_i;
        CfgSrcPort:        l4_src_match_q   <= cfg_data_i[15:0];
        CfgDstPort:        l4_dst_match_q   <= cfg_data_i[15:0];
        CfgAcceptLimit:    accept_limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;
  logic       in_ready;

  // A last byte can only move on when the result register is free or being emptied.
  assign advance  = !(in_last_q && result_o.valid && !result_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign frame_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && frame_i.valid) begin
      in_byte_q <= frame_i.frame_byte;
      in_last_q <= frame_i.last_byte;
    end
  end

  // Frame state.
  logic [OffW-1:0] byte_offset_q, byte_offset_d;
  logic [3:0]      header_words_q, header_words_d;
  logic [15:0]     ether_type_q, ether_type_d;
  logic [7:0]      ip_protocol_q, ip_protocol_d;
  logic [31:0]     src_addr_q, src_addr_d;
  logic [31:0]     dst_addr_q, dst_addr_d;
  logic [15:0]     l4_src_q, l4_src_d;
  logic [15:0]     l4_dst_q, l4_dst_d;
  logic [31:0]     accepted_q, accepted_d;

  logic                capture;
  logic [OffW-1:0]     len;
  logic [PortOffW-1:0] port_base;
  logic [PortOffW-1:0] port_end;
  logic [OffW-1:0]     port_off;
  logic                is_l4;
  logic                ports_seen;
  verdict_e            verdict;

  always_comb begin
    capture        = byte_offset_q < MaxOff;
    header_words_d = header_words_q;
    ether_type_d   = ether_type_q;
    ip_protocol_d  = ip_protocol_q;
    src_addr_d     = src_addr_q;
    dst_addr_d     = dst_addr_q;
    l4_src_d       = l4_src_q;
    l4_dst_d       = l4_dst_q;

    if (capture) begin
      if (byte_offset_q == OffW'(OffEtherHi) || byte_offset_q == OffW'(OffEtherLo)) begin
        ether_type_d = {ether_type_q[7:0], in_byte_q};
      end
      if (byte_offset_q == OffW'(OffIhl)) begin
        header_words_d = in_byte_q[3:0];
      end
      if (byte_offset_q == OffW'(OffProtocol)) begin
        ip_protocol_d = in_byte_q;
      end
      if (byte_offset_q >= OffW'(OffSrcFirst) && byte_offset_q <= OffW'(OffSrcLast)) begin
        src_addr_d = {src_addr_q[23:0], in_byte_q};
      end
      if (byte_offset_q >= OffW'(OffDstFirst) && byte_offset_q <= OffW'(OffDstLast)) begin
        dst_addr_d = {dst_addr_q[23:0], in_byte_q};
      end
    end

    // Ports start after the IPv4 header, whose length may come from this very byte.
    port_base = PortOffW'(OffIhl) + PortOffW'({header_words_d, 2'b00});
    port_end  = port_base + PortOffW'(WordBytes);
    port_off  = OffW'(port_base);
    if (capture) begin
      if (byte_offset_q == port_off || byte_offset_q == port_off + OffW'(1)) begin
        l4_src_d = {l4_src_q[7:0], in_byte_q};
      end
      if (byte_offset_q == port_off + OffW'(2) || byte_offset_q == port_off + OffW'(3)) begin
        l4_dst_d = {l4_dst_q[7:0], in_byte_q};
      end
    end

    len        = capture ? byte_offset_q + OffW'(1) : byte_offset_q;
    is_l4      = (ip_protocol_d == ProtoTcp) || (ip_protocol_d == ProtoUdp);
    ports_seen = len >= OffW'(port_end);

    // Checks in priority order; the first failure decides.
    if (accept_limit_q != '0 && accepted_q >= accept_limit_q) begin
      verdict = VerdictLimit;
    end else if (len < OffW'(MinLenEther)) begin
      verdict = VerdictShort;
    end else if (ether_type_d != EtherTypeIpv4) begin
      verdict = VerdictNotIpv4;
    end else if (len < OffW'(MinLenProtocol)) begin
      verdict = VerdictShort;
    end else if (proto_match_q != '0 && ip_protocol_d != proto_match_q) begin
      verdict = VerdictProtocol;
    end else if ((proto_class_q == ClassTcp && ip_protocol_d != ProtoTcp)
              || (proto_class_q == ClassUdp && ip_protocol_d != ProtoUdp)
              || (proto_class_q == ClassIcmp && ip_protocol_d != ProtoIcmp)) begin
      verdict = VerdictProtocol;
    end else if (len < OffW'(MinLenAddress)) begin
      verdict = VerdictShort;
    end else if ((addr_en_q[0] && src_addr_d != src_addr_match_q)
              || (addr_en_q[1] && dst_addr_d != dst_addr_match_q)) begin
      verdict = VerdictAddress;
    end else if (is_l4 && !ports_seen) begin
      verdict = VerdictShort;
    end else if (is_l4 && ((l4_src_match_q != '0 && l4_src_d != l4_src_match_q)
                        || (l4_dst_match_q != '0 && l4_dst_d != l4_dst_match_q))) begin
      verdict = VerdictPort;
    end else begin
      verdict = VerdictAccept;
    end

    accepted_d = accepted_q;
    if (verdict == VerdictAccept && accepted_q != '1) begin
      accepted_d = accepted_q + 32'd1;
    end

    byte_offset_d = in_last_q ? '0 : len;
  end

  logic step;
  logic finish;
  assign step   = in_valid_q && advance;
  assign finish = step && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q  <= '0;
      header_words_q <= '0;
      ether_type_q   <= '0;
      ip_protocol_q  <= '0;
      src_addr_q     <= '0;
      dst_addr_q     <= '0;
      l4_src_q       <= '0;
      l4_dst_q       <= '0;
      accepted_q     <= '0;
    end else if (step) begin
      byte_offset_q <= byte_offset_d;
      if (in_last_q) begin
        // The frame is done: clear all per-frame capture state.
        header_words_q <= '0;
        ether_type_q   <= '0;
        ip_protocol_q  <= '0;
        src_addr_q     <= '0;
        dst_addr_q     <= '0;
        l4_src_q       <= '0;
        l4_dst_q       <= '0;
        accepted_q     <= accepted_d;
      end else begin
        header_words_q <= header_words_d;
        ether_type_q   <= ether_type_d;
        ip_protocol_q  <= ip_protocol_d;
        src_addr_q     <= src_addr_d;
        dst_addr_q     <= dst_addr_d;
        l4_src_q       <= l4_src_d;
        l4_dst_q       <= l4_dst_d;
      end
    end
  end

  // Result register.
  logic        out_valid_q;
  verdict_e    out_verdict_q;
  logic [7:0]  out_proto_q;
  logic [15:0] out_l4_src_q;
  logic [15:0] out_l4_dst_q;
  logic [31:0] out_total_q;
  logic        proto_seen;

  assign proto_seen = len >= OffW'(MinLenProtocol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_verdict_q <= verdict;
      out_proto_q   <= proto_seen ? ip_protocol_d : 8'd0;
      out_l4_src_q  <= (is_l4 && proto_seen && ports_seen) ? l4_src_d : 16'd0;
      out_l4_dst_q  <= (is_l4 && proto_seen && ports_seen) ? l4_dst_d : 16'd0;
      out_total_q   <= accepted_d;
    end
  end

  assign result_o.valid                  = out_valid_q;
  assign result_o.verdict                = out_verdict_q;
  assign result_o.found_protocol         = out_proto_q;
  assign result_o.found_source_port      = out_l4_src_q;
  assign result_o.found_destination_port = out_l4_dst_q;
  assign result_o.accepted_total         = out_total_q;

  // The accept counter only ever grows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> accepted_q >= $past(accepted_q))
    else $error("accept counter decreased");

  // The frame length never runs past the frame limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_offset_q <= MaxOff)
    else $error("byte offset beyond frame limit");

  // A finished frame restarts at offset zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> byte_offset_q == '0)
    else $error("byte offset not cleared after last byte");

  // An accepting verdict always comes with a nonzero total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_verdict_q == VerdictAccept |-> out_total_q != '0)
    else $error("accepted verdict with zero total");

  // Input back-pressure only comes from a last byte waiting on a full result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> in_valid_q && in_last_q && out_valid_q)
    else $error("input stalled without cause");

endmodule

FILE: test/ipf_verdict_checker.sv
// Checker that predicts the filter verdicts from the observed byte stream and compares them.
module ipf_verdict_checker
  import ipf_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ipf_byte_if                  frame_i,
  ipf_verdict_if               result_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 drain_check_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          verdicts_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  found_protocol;
    logic [15:0] found_l4_src;
    logic [15:0] found_l4_dst;
    logic [31:0] accepted_total;
  } verdict_rec_t;

  // Filter settings as last written.
  logic [7:0]   want_protocol;
  proto_class_e want_class;
  logic [1:0]   addr_enable;
  logic [31:0]  want_src_addr;
  logic [31:0]  want_dst_addr;
  logic [15:0]  want_l4_src;
  logic [15:0]  want_l4_dst;
  logic [31:0]  accept_limit;

  // Per-frame capture state.
  int unsigned byte_count;
  logic [3:0]  hdr_words;
  logic [15:0] ether_type;
  logic [7:0]  ip_proto;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] l4_src;
  logic [15:0] l4_dst;
  logic [31:0] accepted_count;

  verdict_rec_t pending_verdicts[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count_o++;
  endtask

  function automatic void clear_frame();
    byte_count = 0;
    hdr_words  = '0;
    ether_type = '0;
    ip_proto   = '0;
    src_addr   = '0;
    dst_addr   = '0;
    l4_src     = '0;
    l4_dst     = '0;
  endfunction

  function automatic verdict_e classify(input int unsigned len, input bit l4,
                                        input int unsigned port_end);
    if (accept_limit != 0 && accepted_count >= accept_limit) return VerdictLimit;
    if (len < MinLenEther) return VerdictShort;
    if (ether_type != EtherTypeIpv4) return VerdictNotIpv4;
    if (len < MinLenProtocol) return VerdictShort;
    if (want_protocol != 0 && ip_proto != want_protocol) return VerdictProtocol;
    case (want_class)
      ClassTcp: if (ip_proto != ProtoTcp) return VerdictProtocol;
      ClassUdp: if (ip_proto != ProtoUdp) return VerdictProtocol;
      ClassIcmp: if (ip_proto != ProtoIcmp) return VerdictProtocol;
      default: ;
    endcase
    if (len < MinLenAddress) return VerdictShort;
    if (addr_enable[0] && src_addr != want_src_addr) return VerdictAddress;
    if (addr_enable[1] && dst_addr != want_dst_addr) return VerdictAddress;
    if (l4) begin
      if (len < port_end) return VerdictShort;
      if (want_l4_src != 0 && l4_src != want_l4_src) return VerdictPort;
      if (want_l4_dst != 0 && l4_dst != want_l4_dst) return VerdictPort;
    end
    return VerdictAccept;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic last);
    int unsigned  port_off;
    int unsigned  port_end;
    bit           l4;
    verdict_rec_t rec;
    // Bytes past the size limit are dropped, so the length saturates there.
    if (byte_count < MAX_FRAME_BYTES) begin
      if (byte_count == OffEtherHi || byte_count == OffEtherLo) begin
        ether_type = {ether_type[7:0], b};
      end
      if (byte_count == OffIhl) hdr_words = b[3:0];
      if (byte_count == OffProtocol) ip_proto = b;
      if (byte_count >= OffSrcFirst && byte_count <= OffSrcLast) src_addr = {src_addr[23:0], b};
      if (byte_count >= OffDstFirst && byte_count <= OffDstLast) dst_addr = {dst_addr[23:0], b};
      // The port offset already follows a header length taken from this same byte.
      port_off = OffIhl + WordBytes * hdr_words;
      if (byte_count == port_off || byte_count == port_off + 1) begin
        l4_src = {l4_src[7:0], b};
      end
      if (byte_count == port_off + 2 || byte_count == port_off + 3) begin
        l4_dst = {l4_dst[7:0], b};
      end
      byte_count++;
    end
    if (last) begin
      l4 = (ip_proto == ProtoTcp) || (ip_proto == ProtoUdp);
      port_end = OffIhl + WordBytes * hdr_words + 4;
      rec.verdict = classify(byte_count, l4, port_end);
      if (rec.verdict == VerdictAccept && accepted_count != '1) accepted_count++;
      rec.found_protocol = (byte_count >= MinLenProtocol) ? ip_proto : '0;
      if (l4 && byte_count >= MinLenProtocol && byte_count >= port_end) begin
        rec.found_l4_src = l4_src;
        rec.found_l4_dst = l4_dst;
      end else begin
        rec.found_l4_src = '0;
        rec.found_l4_dst = '0;
      end
      rec.accepted_total = accepted_count;
      pending_verdicts.push_back(rec);
      clear_frame();
    end
  endtask

  task automatic apply_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (cfg_index_e'(idx))
      CfgProtocolNumber: want_protocol = data[7:0];
      CfgProtocolClass: want_class = proto_class_e'(data[1:0]);
      CfgAddrEnable: addr_enable = data[1:0];
      CfgSrcAddr: want_src_addr = data;
      CfgDstAddr: want_dst_addr = data;
      CfgSrcPort: want_l4_src = data[15:0];
      CfgDstPort: want_l4_dst = data[15:0];
      CfgAcceptLimit: accept_limit = data;
      default: ;
    endcase
  endtask

  task automatic check_verdict();
    verdict_rec_t rec;
    int unsigned  n;
    n = verdicts_seen_o;
    if (pending_verdicts.size() == 0) begin
      report_mismatch($sformatf("verdict %0d arrived with none expected (verdict %0d)",
                                n, result_i.verdict));
    end else begin
      rec = pending_verdicts.pop_front();
      if (result_i.verdict !== rec.verdict) begin
        report_mismatch($sformatf("verdict %0d: verdict got %0d, expected %0d",
                                  n, result_i.verdict, rec.verdict));
      end
      if (result_i.found_protocol !== rec.found_protocol) begin
        report_mismatch($sformatf("verdict %0d: protocol got 0x%0h, expected 0x%0h",
                                  n, result_i.found_protocol, rec.found_protocol));
      end
      if (result_i.found_source_port !== rec.found_l4_src) begin
        report_mismatch($sformatf("verdict %0d: source port got 0x%0h, expected 0x%0h",
                                  n, result_i.found_source_port, rec.found_l4_src));
      end
      if (result_i.found_destination_port !== rec.found_l4_dst) begin
        report_mismatch($sformatf("verdict %0d: destination port got 0x%0h, expected 0x%0h",
                                  n, result_i.found_destination_port, rec.found_l4_dst));
      end
      if (result_i.accepted_total !== rec.accepted_total) begin
        report_mismatch($sformatf("verdict %0d: accepted total got %0d, expected %0d",
                                  n, result_i.accepted_total, rec.accepted_total));
      end
    end
    verdicts_seen_o <= verdicts_seen_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_protocol    = '0;
      want_class       = ClassAny;
      addr_enable      = '0;
      want_src_addr    = '0;
      want_dst_addr    = '0;
      want_l4_src      = '0;
      want_l4_dst      = '0;
      accept_limit     = '0;
      accepted_count   = '0;
      clear_frame();
      pending_verdicts.delete();
      mismatch_count_o = 0;
      verdicts_seen_o <= 0;
    end else begin
      // A verdict can never belong to a byte taken in the same cycle, so compare first.
      if (result_i.valid && result_i.ready) check_verdict();
      if (cfg_we_i) apply_reg(cfg_index_i, cfg_data_i);
      if (frame_i.valid && frame_i.ready) take_byte(frame_i.frame_byte, frame_i.last_byte);
      if (drain_check_i) begin
        while (pending_verdicts.size() > 0) begin
          report_mismatch($sformatf("expected verdict %0d never arrived",
                                    pending_verdicts[0].verdict));
          void'(pending_verdicts.pop_front());
        end
      end
    end
  end

endmodule

FILE: test/tb.sv
// Top-level testbench: frame stimulus, filter settings, verdict sink and final verdict.
module tb
  import ipf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit    = 5000;
  localparam int unsigned RandomByteTarget = 700;
  localparam int unsigned RandomFrameMin   = 16;
  localparam int unsigned SettleCycles     = 6;
  // A small frame limit keeps the overlong-frame case short.
  localparam int unsigned TbMaxFrameBytes  = 128;

  typedef struct packed {
    logic [7:0]   proto_match;
    proto_class_e proto_class;
    logic [1:0]   addr_en;
    logic [31:0]  src_addr;
    logic [31:0]  dst_addr;
    logic [15:0]  l4_src;
    logic [15:0]  l4_dst;
    logic [31:0]  limit;
  } filter_cfg_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  cfg_index_e           cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  logic                 drain_check;
  int unsigned          mismatch_count;
  int unsigned          verdicts_seen;

  int unsigned frames_sent;
  int unsigned bytes_sent;
  int unsigned idle_cycles = 0;
  bit          steady_run;
  logic [7:0]  frame_bytes[];

  ipf_byte_if    frame_ch ();
  ipf_verdict_if result_ch ();

  ipv4_header_packet_filter_core #(
    .MAX_FRAME_BYTES (TbMaxFrameBytes)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame_ch),
    .result_o    (result_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ipf_verdict_checker #(
    .MAX_FRAME_BYTES (TbMaxFrameBytes)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frame_i          (frame_ch),
    .result_i         (result_ch),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .drain_check_i    (drain_check),
    .mismatch_count_o (mismatch_count),
    .verdicts_seen_o  (verdicts_seen)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic void put_byte(input int unsigned off, input logic [7:0] v);
    if (off < frame_bytes.size()) frame_bytes[off] = v;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_ch.valid      <= 1'b1;
    frame_ch.frame_byte <= b;
    frame_ch.last_byte  <= last;
    do @(posedge clk_i); while (!frame_ch.ready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    frames_sent++;
    bytes_sent += frame_bytes.size();
  endtask

  // Random filler with the header fields laid over it; the header wins where the
  // ports overlap it, so the length nibble stays as given.
  task automatic send_ipv4(input logic [15:0] etype, input logic [3:0] hw,
                           input logic [7:0] proto, input logic [31:0] src,
                           input logic [31:0] dst, input logic [15:0] sport,
                           input logic [15:0] dport, input int unsigned len);
    int unsigned port_off;
    frame_bytes = new[len];
    foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom);
    port_off = OffIhl + WordBytes * hw;
    put_byte(port_off, sport[15:8]);
    put_byte(port_off + 1, sport[7:0]);
    put_byte(port_off + 2, dport[15:8]);
    put_byte(port_off + 3, dport[7:0]);
    put_byte(OffEtherHi, etype[15:8]);
    put_byte(OffEtherLo, etype[7:0]);
    put_byte(OffIhl, {4'h4, hw});
    put_byte(OffProtocol, proto);
    for (int k = 0; k < 4; k++) begin
      put_byte(OffSrcFirst + k, src[31 - 8 * k -: 8]);
      put_byte(OffDstFirst + k, dst[31 - 8 * k -: 8]);
    end
    send_frame();
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_filter(input filter_cfg_t c);
    write_reg(CfgProtocolNumber, {24'd0, c.proto_match});
    write_reg(CfgProtocolClass, {30'd0, c.proto_class});
    write_reg(CfgAddrEnable, {30'd0, c.addr_en});
    write_reg(CfgSrcAddr, c.src_addr);
    write_reg(CfgDstAddr, c.dst_addr);
    write_reg(CfgSrcPort, {16'd0, c.l4_src});
    write_reg(CfgDstPort, {16'd0, c.l4_dst});
    write_reg(CfgAcceptLimit, c.limit);
    cfg_we <= 1'b0;
  endtask

  // Bytes that end no frame give no verdict, so wait for one verdict per frame, then settle.
  task automatic wait_idle();
    frame_ch.valid <= 1'b0;
    while (verdicts_seen < frames_sent) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic filter_cfg_t random_filter();
    filter_cfg_t c;
    int unsigned r;
    c = '0;
    if ($urandom_range(0, 9) == 0) return c;
    r = $urandom_range(0, 99);
    if (r < 50) c.proto_match = 8'd0;
    else if (r < 60) c.proto_match = ProtoTcp;
    else if (r < 70) c.proto_match = ProtoUdp;
    else if (r < 75) c.proto_match = ProtoIcmp;
    else c.proto_match = 8'($urandom_range(1, 255));
    c.proto_class = ($urandom_range(0, 99) < 40) ? ClassAny
                                                  : proto_class_e'($urandom_range(0, 3));
    c.addr_en  = 2'($urandom_range(0, 3));
    c.src_addr = $urandom;
    c.dst_addr = $urandom;
    c.l4_src   = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    c.l4_dst   = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    r = $urandom_range(0, 99);
    if (r < 70) c.limit = '0;
    else if (r < 85) c.limit = '1;
    else c.limit = $urandom_range(1, 60);
    return c;
  endfunction

  // Frames are mostly built to pass the current filter so that the later checks get
  // reached; others break fields at random, are cut short, or are plain noise.
  task automatic random_frame(input filter_cfg_t c);
    logic [15:0] etype;
    logic [3:0]  hw;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    int unsigned span;
    int unsigned len;
    int unsigned r;
    if ($urandom_range(0, 99) < 8) begin
      frame_bytes = new[$urandom_range(1, 48)];
      foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom);
      send_frame();
      return;
    end
    etype = ($urandom_range(0, 99) < 88) ? EtherTypeIpv4 : 16'($urandom);
    hw    = ($urandom_range(0, 99) < 75) ? 4'd5 : 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 35 && c.proto_match != 0) begin
      proto = c.proto_match;
    end else if (r < 60 && c.proto_class != ClassAny) begin
      case (c.proto_class)
        ClassTcp: proto = ProtoTcp;
        ClassUdp: proto = ProtoUdp;
        default: proto = ProtoIcmp;
      endcase
    end else if (r < 88) begin
      case ($urandom_range(0, 2))
        0: proto = ProtoTcp;
        1: proto = ProtoUdp;
        default: proto = ProtoIcmp;
      endcase
    end else begin
      proto = 8'($urandom);
    end
    src   = ($urandom_range(0, 99) < 80) ? c.src_addr : $urandom;
    dst   = ($urandom_range(0, 99) < 80) ? c.dst_addr : $urandom;
    sport = ($urandom_range(0, 99) < 80) ? c.l4_src : 16'($urandom);
    dport = ($urandom_range(0, 99) < 80) ? c.l4_dst : 16'($urandom);
    span = OffIhl + WordBytes * hw + 4;
    if (span < MinLenAddress) span = MinLenAddress;
    r = $urandom_range(0, 99);
    if (r < 72) len = span + $urandom_range(0, 12);
    else if (r < 92) len = $urandom_range(1, span - 1);
    else len = $urandom_range(span, 120);
    send_ipv4(etype, hw, proto, src, dst, sport, dport, len);
  endtask

  // Result side: runs of ready broken by stalls of random length.
  initial begin
    int unsigned run;
    int unsigned gap;
    result_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      run = $urandom_range(1, 20);
      result_ch.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("[%0t] no transfer for %0d cycles", $time, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    filter_cfg_t filt;
    int unsigned random_frames;
    int unsigned random_start;
    int unsigned phase_frames;
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CfgProtocolNumber;
    cfg_data            <= '0;
    drain_check         <= 1'b0;
    frame_ch.valid      <= 1'b0;
    frame_ch.frame_byte <= '0;
    frame_ch.last_byte  <= 1'b0;
    frames_sent = 0;
    bytes_sent  = 0;
    steady_run  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Filters all off after reset: the length and ethertype checks alone.
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoTcp, 32'h0, 32'h0, 16'h0, 16'h0, 1);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoTcp, 32'h0, 32'h0, 16'h0, 16'h0, 13);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoTcp, 32'h0, 32'h0, 16'h0, 16'h0, 14);
    send_ipv4(16'h86DD, 4'd5, ProtoTcp, 32'h0, 32'h0, 16'h0, 16'h0, 60);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoIcmp, 32'h1, 32'h2, 16'h0, 16'h0, 24);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoIcmp, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'h0, 34);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoTcp, 32'h0A00_0001, 32'h0A00_0002,
              16'hFFFF, 16'h0000, 44);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoUdp, 32'h0A00_0001, 32'h0A00_0002,
              16'd53, 16'd53, 37);
    // Header length below five words: the ports sit inside the IPv4 header; then fifteen words.
    send_ipv4(EtherTypeIpv4, 4'd0, ProtoTcp, 32'h0, 32'hFFFF_FFFF, 16'h1234, 16'h5678, 34);
    send_ipv4(EtherTypeIpv4, 4'd15, ProtoUdp, 32'h0, 32'h0, 16'h8000, 16'h0001, 78);
    // Overlong frame: the length saturates at the frame size limit.
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoUdp, 32'h0, 32'h0, 16'd7, 16'd9,
              TbMaxFrameBytes + 52);
    frame_bytes = new[40];
    foreach (frame_bytes[i]) frame_bytes[i] = 8'hFF;
    send_frame();
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    send_frame();

    // Every setting at its maximum.
    wait_idle();
    apply_filter('{8'hFF, ClassIcmp, 2'b11, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF});
    send_ipv4(EtherTypeIpv4, 4'd5, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              16'hFFFF, 16'hFFFF, 40);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoIcmp, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              16'hFFFF, 16'hFFFF, 40);

    // A full TCP five-tuple, then one field broken at a time.
    filt = '{ProtoTcp, ClassTcp, 2'b11, 32'h0A00_0001, 32'hC0A8_01FE,
             16'd443, 16'd51000, 32'd0};
    wait_idle();
    apply_filter(filt);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoTcp, filt.src_addr, filt.dst_addr,
              filt.l4_src, filt.l4_dst, 54);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoTcp, 32'h0A00_0002, filt.dst_addr,
              filt.l4_src, filt.l4_dst, 54);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoTcp, filt.src_addr, 32'hC0A8_01FF,
              filt.l4_src, filt.l4_dst, 54);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoTcp, filt.src_addr, filt.dst_addr,
              16'd80, filt.l4_dst, 54);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoTcp, filt.src_addr, filt.dst_addr,
              filt.l4_src, 16'd51001, 54);
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoUdp, filt.src_addr, filt.dst_addr,
              filt.l4_src, filt.l4_dst, 54);

    // The accept count is already past a limit of one.
    wait_idle();
    apply_filter('{8'd0, ClassAny, 2'b00, 32'd0, 32'd0, 16'd0, 16'd0, 32'd1});
    send_ipv4(EtherTypeIpv4, 4'd5, ProtoTcp, 32'h0, 32'h0, 16'h0, 16'h0, 44);

    random_frames = 0;
    random_start  = bytes_sent;
    while (bytes_sent - random_start < RandomByteTarget || random_frames < RandomFrameMin) begin
      filt = random_filter();
      wait_idle();
      apply_filter(filt);
      phase_frames = $urandom_range(4, 12);
      repeat (phase_frames) begin
        steady_run = ($urandom_range(0, 6) == 0);
        random_frame(filt);
        random_frames++;
      end
    end
    steady_run = 1'b0;

    wait_idle();
    drain_check <= 1'b1;
    @(posedge clk_i);
    drain_check <= 1'b0;
    @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ipf_pkg.sv
rtl/core/ipf_channels.sv
rtl/core/ipv4_header_packet_filter_core.sv
test/ipf_verdict_checker.sv
test/tb.sv
